### rtl/core/pwmss_pkg.sv
// Package for the PWM soft-start sequencer: item codes, phase type,
// register indexes, reset values and field widths. No dependencies.
package pwmss_pkg;

    localparam int PERIOD_W   = 16;
    localparam int DEADTIME_W = 10;
    localparam int COUNT_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 24;
    localparam int S_USER_W   = 2;
    localparam int OUT_W      = 77;
    localparam int M_DATA_W   = 80;

    localparam logic [PERIOD_W-1:0] BURST_THRESHOLD = PERIOD_W'(400);
    localparam logic [PERIOD_W-1:0] PERIOD_FLOOR    = PERIOD_W'(2);

    localparam logic [PERIOD_W-1:0]   RST_PERIOD_START   = PERIOD_W'(399);
    localparam logic [PERIOD_W-1:0]   RST_PERIOD_FINAL   = PERIOD_W'(428);
    localparam logic [PERIOD_W-1:0]   RST_PERIOD_STEP    = PERIOD_W'(1);
    localparam logic [DEADTIME_W-1:0] RST_DEADTIME_START = DEADTIME_W'(190);
    localparam logic [DEADTIME_W-1:0] RST_DEADTIME_FINAL = DEADTIME_W'(36);
    localparam logic [DEADTIME_W-1:0] RST_DEADTIME_STEP  = DEADTIME_W'(1);
    localparam logic [COUNT_W-1:0]    RST_WAIT_TICKS     = COUNT_W'(20);

    // item kinds
    localparam logic [1:0] OP_SLOW  = 2'd0;
    localparam logic [1:0] OP_FAST  = 2'd1;
    localparam logic [1:0] OP_BEGIN = 2'd2;

    // PWM commands
    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_BURST   = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // abort reasons
    localparam logic [1:0] ABORT_NONE = 2'd0;
    localparam logic [1:0] ABORT_COMP = 2'd1;
    localparam logic [1:0] ABORT_CFG  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_START   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_FINAL   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_STEP    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADTIME_START = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADTIME_FINAL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DEADTIME_STEP  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_WAIT_TICKS     = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_BURST_ENABLE   = 3'd7;

    typedef enum logic [2:0] {
        PH_INIT  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_RAMP  = 3'd2,
        PH_FINAL = 3'd3,
        PH_DONE  = 3'd4,
        PH_ABORT = 3'd5
    } t_phase;

endpackage

### rtl/core/pwm_soft_start_sequencer_core.sv
// Top level of the PWM soft-start sequencer: input register, sequencing
// logic, result register and configuration registers. Uses pwmss_pkg.

// One result per input item. A transfer is taken every cycle when the result
// side keeps up. An item waits in the input register until the result register
// is free or being taken, and its result is then registered there. All sequencer
// state (phase, wait counter, ramped limit and dead-time, burst and commit
// flags) updates in the cycle an item moves from the input register to the
// result register, so each item sees the state left by the one before it.
// Configuration writes take effect on the next clock; begin items clear the
// burst enable register unless a configuration write comes in the same cycle.
module pwm_soft_start_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] in_soft_start, [16:1] req_period, [17] comparator_ok,
    // [18] prepare_ok, [19] pwm_running, [20] fault_present, [21] write_ok
    input  logic [pwmss_pkg::S_DATA_W-1:0]      s_axis_tdata,
    // [1:0] op
    input  logic [pwmss_pkg::S_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] phase, [18:3] ramp_limit, [34:19] applied_period,
    // [44:35] deadtime, [46:45] pwm_command, [47] write_valid,
    // [63:48] write_period, [73:64] write_deadtime, [75:74] abort_reason,
    // [76] run_request
    output logic [pwmss_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [pwmss_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [pwmss_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import pwmss_pkg::*;

    // configuration
    logic [PERIOD_W-1:0]   r_period_start, r_period_final, r_period_step;
    logic [DEADTIME_W-1:0] r_deadtime_start, r_deadtime_final, r_deadtime_step;
    logic [COUNT_W-1:0]    r_wait_ticks;
    logic                  r_burst_enable, n_burst_enable;

    // input register
    logic                  r_in_valid;
    logic [S_DATA_W-1:0]   r_in_data;
    logic [S_USER_W-1:0]   r_in_op;

    // sequencer state
    t_phase                r_phase, n_phase;
    logic [COUNT_W-1:0]    r_wait_count, n_wait_count;
    logic [PERIOD_W-1:0]   r_limit, n_limit;
    logic [DEADTIME_W-1:0] r_deadtime, n_deadtime;
    logic                  r_burst_active, n_burst_active;
    logic                  r_final_pending, n_final_pending;
    logic                  r_final_done, n_final_done;

    // result register
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data, n_out_data;

    logic                  w_proc;
    logic                  w_soft, w_comp_ok, w_prep_ok, w_running, w_fault, w_wr_ok;
    logic [PERIOD_W-1:0]   w_req_raw, w_req, w_min, w_applied;
    logic [PERIOD_W:0]     w_lim_sum;
    logic [PERIOD_W-1:0]   w_lim_ramp;
    logic [DEADTIME_W-1:0] w_dt_dec, w_dt_ramp;
    logic [COUNT_W-1:0]    w_wait_inc;
    logic                  w_eff;
    logic [1:0]            w_cmd, w_reason;
    logic                  w_run, w_wvalid;
    logic [PERIOD_W-1:0]   w_wper;
    logic [DEADTIME_W-1:0] w_wdt;

    assign w_proc        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proc;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(M_DATA_W - OUT_W)'(0), r_out_data};

    assign w_soft    = r_in_data[0];
    assign w_req_raw = r_in_data[16:1];
    assign w_comp_ok = r_in_data[17];
    assign w_prep_ok = r_in_data[18];
    assign w_running = r_in_data[19];
    assign w_fault   = r_in_data[20];
    assign w_wr_ok   = r_in_data[21];

    // ramp step values
    assign w_lim_sum  = {1'b0, r_limit} + {1'b0, r_period_step};
    assign w_wait_inc = r_wait_count + COUNT_W'(1);

    always_comb begin
        w_lim_ramp = r_limit;
        if (r_limit < r_period_final) begin
            w_lim_ramp = (w_lim_sum > {1'b0, r_period_final}) ? r_period_final
                                                               : w_lim_sum[PERIOD_W-1:0];
        end
    end

    always_comb begin
        w_dt_dec  = (r_deadtime >= r_deadtime_step) ? (r_deadtime - r_deadtime_step)
                                                    : r_deadtime_final;
        w_dt_ramp = r_deadtime;
        if (r_deadtime > r_deadtime_final) begin
            w_dt_ramp = (w_dt_dec < r_deadtime_final) ? r_deadtime_final : w_dt_dec;
        end
    end

    // next state and result
    always_comb begin
        n_phase         = r_phase;
        n_wait_count    = r_wait_count;
        n_limit         = r_limit;
        n_deadtime      = r_deadtime;
        n_burst_active  = r_burst_active;
        n_final_pending = r_final_pending;
        n_final_done    = r_final_done;
        n_burst_enable  = r_burst_enable;
        w_cmd           = CMD_NONE;
        w_reason        = ABORT_NONE;
        w_run           = 1'b0;
        w_wvalid        = 1'b0;
        w_wper          = '0;
        w_wdt           = '0;
        w_eff           = w_running;

        if (r_in_op == OP_BEGIN) begin
            n_phase         = PH_INIT;
            n_wait_count    = '0;
            n_limit         = r_period_start;
            n_deadtime      = r_deadtime_start;
            n_burst_active  = 1'b0;
            n_final_pending = 1'b0;
            n_final_done    = 1'b0;
            n_burst_enable  = 1'b0;
        end else if (r_in_op == OP_SLOW && w_soft) begin
            unique case (r_phase)
                PH_INIT: begin
                    n_phase = PH_WAIT;
                end
                PH_WAIT: begin
                    n_wait_count = w_wait_inc;
                    if (w_wait_inc >= r_wait_ticks) begin
                        n_wait_count = '0;
                        if (!w_comp_ok) begin
                            w_reason = ABORT_COMP;
                            n_phase  = PH_ABORT;
                        end else if (!w_prep_ok) begin
                            w_reason = ABORT_CFG;
                            n_phase  = PH_ABORT;
                        end else begin
                            w_cmd   = CMD_START;
                            n_phase = PH_RAMP;
                        end
                    end
                end
                PH_RAMP: begin
                    n_limit    = w_lim_ramp;
                    n_deadtime = w_dt_ramp;
                    if (w_lim_ramp >= r_period_final && w_dt_ramp <= r_deadtime_final) begin
                        n_phase = PH_FINAL;
                    end
                end
                PH_FINAL: begin
                    if (r_final_done && w_running && !w_fault) begin
                        n_phase = PH_DONE;
                        w_run   = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        w_req     = (w_req_raw == '0) ? r_period_start : w_req_raw;
        w_min     = (w_req < n_limit) ? w_req : n_limit;
        w_applied = (w_min < PERIOD_FLOOR) ? PERIOD_FLOOR : w_min;

        if (r_in_op == OP_FAST && w_soft) begin
            if (r_burst_enable) begin
                if (w_req_raw < BURST_THRESHOLD && w_running) begin
                    if (!r_burst_active) begin
                        w_cmd          = CMD_BURST;
                        n_burst_active = 1'b1;
                        w_eff          = 1'b0;
                    end
                end else if (r_burst_active) begin
                    w_cmd          = CMD_RESTART;
                    n_burst_active = 1'b0;
                    w_eff          = 1'b1;
                end
            end
            if (w_eff) begin
                w_wvalid = 1'b1;
                if (r_phase == PH_FINAL) begin
                    w_wper = r_period_final;
                    w_wdt  = r_deadtime_final;
                    if (w_wr_ok) begin
                        if (!r_final_pending) begin
                            n_final_pending = 1'b1;
                        end else begin
                            n_final_done = 1'b1;
                        end
                    end
                end else begin
                    w_wper = w_applied;
                    w_wdt  = r_deadtime;
                end
            end
        end

        n_out_data = {w_run, w_reason, w_wdt, w_wper, w_wvalid, w_cmd,
                      n_deadtime, w_applied, n_limit, 3'(n_phase)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_data <= s_axis_tdata;
            r_in_op   <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_INIT;
            r_wait_count    <= '0;
            r_limit         <= RST_PERIOD_START;
            r_deadtime      <= RST_DEADTIME_START;
            r_burst_active  <= 1'b0;
            r_final_pending <= 1'b0;
            r_final_done    <= 1'b0;
        end else if (w_proc) begin
            r_phase         <= n_phase;
            r_wait_count    <= n_wait_count;
            r_limit         <= n_limit;
            r_deadtime      <= n_deadtime;
            r_burst_active  <= n_burst_active;
            r_final_pending <= n_final_pending;
            r_final_done    <= n_final_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_start   <= RST_PERIOD_START;
            r_period_final   <= RST_PERIOD_FINAL;
            r_period_step    <= RST_PERIOD_STEP;
            r_deadtime_start <= RST_DEADTIME_START;
            r_deadtime_final <= RST_DEADTIME_FINAL;
            r_deadtime_step  <= RST_DEADTIME_STEP;
            r_wait_ticks     <= RST_WAIT_TICKS;
            r_burst_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_PERIOD_START:   r_period_start   <= i_cfg_wdata;
                REG_PERIOD_FINAL:   r_period_final   <= i_cfg_wdata;
                REG_PERIOD_STEP:    r_period_step    <= i_cfg_wdata;
                REG_DEADTIME_START: r_deadtime_start <= i_cfg_wdata[DEADTIME_W-1:0];
                REG_DEADTIME_FINAL: r_deadtime_final <= i_cfg_wdata[DEADTIME_W-1:0];
                REG_DEADTIME_STEP:  r_deadtime_step  <= i_cfg_wdata[DEADTIME_W-1:0];
                REG_WAIT_TICKS:     r_wait_ticks     <= i_cfg_wdata;
                REG_BURST_ENABLE:   r_burst_enable   <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end else if (w_proc) begin
            r_burst_enable <= n_burst_enable;
        end
    end

endmodule

### rtl/core/pwmss_chk.sv
// Port-level checker for the PWM soft-start sequencer, bound to the top
// level. Uses pwmss_pkg.
module pwmss_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [pwmss_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import pwmss_pkg::*;

    logic [2:0]            w_phase;
    logic [PERIOD_W-1:0]   w_applied;
    logic [1:0]            w_cmd;
    logic                  w_wvalid;
    logic [PERIOD_W-1:0]   w_wper;
    logic [DEADTIME_W-1:0] w_wdt;
    logic [1:0]            w_reason;
    logic                  w_run;

    assign w_phase   = m_axis_tdata[2:0];
    assign w_applied = m_axis_tdata[34:19];
    assign w_cmd     = m_axis_tdata[46:45];
    assign w_wvalid  = m_axis_tdata[47];
    assign w_wper    = m_axis_tdata[63:48];
    assign w_wdt     = m_axis_tdata[73:64];
    assign w_reason  = m_axis_tdata[75:74];
    assign w_run     = m_axis_tdata[76];

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_applied >= PERIOD_FLOOR)
        else $error("applied period below floor");

    a_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !w_wvalid |-> w_wper == '0 && w_wdt == '0)
        else $error("write data without write");

    a_abort_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_reason != ABORT_NONE |-> w_phase == 3'(PH_ABORT)
            && w_cmd == CMD_NONE && !w_run)
        else $error("abort without aborted phase");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_cmd == CMD_START || w_run) |->
            (w_cmd == CMD_START && w_phase == 3'(PH_RAMP)) ||
            (w_run && w_phase == 3'(PH_DONE)))
        else $error("start or run outside its phase");

endmodule

bind pwm_soft_start_sequencer_core pwmss_chk u_pwmss_chk (.*);

### verif/pwmss_seq_checker.sv
// Scoreboard for pwm_soft_start_sequencer_core. It mirrors the sequencer from
// input and register write transfers and checks every result transfer.
// Depends on pwmss_pkg.
module pwmss_seq_checker
    import pwmss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    input  logic                  i_s_ready,
    input  logic [S_DATA_W-1:0]   i_s_data,
    input  logic [S_USER_W-1:0]   i_s_user,
    input  logic                  i_m_valid,
    input  logic                  i_m_ready,
    input  logic [M_DATA_W-1:0]   i_m_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_outstanding,
    output int                    o_result_count,
    output int                    o_completed,
    output int                    o_aborted
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]            phase;
        logic [PERIOD_W-1:0]   ramp_limit;
        logic [PERIOD_W-1:0]   applied_period;
        logic [DEADTIME_W-1:0] deadtime;
        logic [1:0]            pwm_command;
        logic                  write_valid;
        logic [PERIOD_W-1:0]   write_period;
        logic [DEADTIME_W-1:0] write_deadtime;
        logic [1:0]            abort_reason;
        logic                  run_request;
    } t_seq_result;

    logic [PERIOD_W-1:0]   cfg_period_start, cfg_period_final, cfg_period_step;
    logic [DEADTIME_W-1:0] cfg_dt_start, cfg_dt_final, cfg_dt_step;
    logic [COUNT_W-1:0]    cfg_wait_ticks;
    logic                  cfg_burst_en;

    t_phase                phase_q;
    logic [COUNT_W-1:0]    wait_cnt;
    logic [PERIOD_W-1:0]   limit_q;
    logic [DEADTIME_W-1:0] dt_q;
    logic                  burst_on, commit_first, commit_done;

    t_seq_result expected_results[$];
    int errors    = 0;
    int results   = 0;
    int completed = 0;
    int aborted   = 0;

    initial begin
        o_fail_count   = 0;
        o_outstanding  = 0;
        o_result_count = 0;
        o_completed    = 0;
        o_aborted      = 0;
    end

    task automatic reload_ramp();
        phase_q      = PH_INIT;
        wait_cnt     = '0;
        limit_q      = cfg_period_start;
        dt_q         = cfg_dt_start;
        burst_on     = 1'b0;
        commit_first = 1'b0;
        commit_done  = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_seq_result         exp_r;
        logic [PERIOD_W-1:0] req_raw, req;
        logic [PERIOD_W:0]   sum;
        logic                ss_on, comp_ok, prep_ok, running, fault, wr_ok, eff;
        if (!i_rst_n) begin
            cfg_period_start = RST_PERIOD_START;
            cfg_period_final = RST_PERIOD_FINAL;
            cfg_period_step  = RST_PERIOD_STEP;
            cfg_dt_start     = RST_DEADTIME_START;
            cfg_dt_final     = RST_DEADTIME_FINAL;
            cfg_dt_step      = RST_DEADTIME_STEP;
            cfg_wait_ticks   = RST_WAIT_TICKS;
            cfg_burst_en     = 1'b0;
            reload_ramp();
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PERIOD_START:   cfg_period_start = i_cfg_wdata;
                    REG_PERIOD_FINAL:   cfg_period_final = i_cfg_wdata;
                    REG_PERIOD_STEP:    cfg_period_step  = i_cfg_wdata;
                    REG_DEADTIME_START: cfg_dt_start     = i_cfg_wdata[DEADTIME_W-1:0];
                    REG_DEADTIME_FINAL: cfg_dt_final     = i_cfg_wdata[DEADTIME_W-1:0];
                    REG_DEADTIME_STEP:  cfg_dt_step      = i_cfg_wdata[DEADTIME_W-1:0];
                    REG_WAIT_TICKS:     cfg_wait_ticks   = i_cfg_wdata;
                    REG_BURST_ENABLE:   cfg_burst_en     = i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_m_valid && i_m_ready) begin
                results++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transfer, expected none actual %h",
                             $time, i_m_data);
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("phase", 32'(exp_r.phase), 32'(i_m_data[2:0]));
                    check_field("ramp_limit", 32'(exp_r.ramp_limit),
                                32'(i_m_data[18:3]));
                    check_field("applied_period", 32'(exp_r.applied_period),
                                32'(i_m_data[34:19]));
                    check_field("deadtime", 32'(exp_r.deadtime), 32'(i_m_data[44:35]));
                    check_field("pwm_command", 32'(exp_r.pwm_command),
                                32'(i_m_data[46:45]));
                    check_field("write_valid", 32'(exp_r.write_valid), 32'(i_m_data[47]));
                    check_field("write_period", 32'(exp_r.write_period),
                                32'(i_m_data[63:48]));
                    check_field("write_deadtime", 32'(exp_r.write_deadtime),
                                32'(i_m_data[73:64]));
                    check_field("abort_reason", 32'(exp_r.abort_reason),
                                32'(i_m_data[75:74]));
                    check_field("run_request", 32'(exp_r.run_request), 32'(i_m_data[76]));
                    if (exp_r.run_request) completed++;
                    if (exp_r.abort_reason != ABORT_NONE) aborted++;
                end
            end

            if (i_s_valid && i_s_ready) begin
                ss_on   = i_s_data[0];
                req_raw = i_s_data[16:1];
                comp_ok = i_s_data[17];
                prep_ok = i_s_data[18];
                running = i_s_data[19];
                fault   = i_s_data[20];
                wr_ok   = i_s_data[21];
                exp_r   = '0;

                if (i_s_user == OP_BEGIN) begin
                    reload_ramp();
                    cfg_burst_en = 1'b0;
                end else if (i_s_user == OP_SLOW && ss_on) begin
                    case (phase_q)
                        PH_INIT: phase_q = PH_WAIT;
                        PH_WAIT: begin
                            wait_cnt = wait_cnt + 1'b1;
                            if (wait_cnt >= cfg_wait_ticks) begin
                                wait_cnt = '0;
                                if (!comp_ok) begin
                                    exp_r.abort_reason = ABORT_COMP;
                                    phase_q = PH_ABORT;
                                end else if (!prep_ok) begin
                                    exp_r.abort_reason = ABORT_CFG;
                                    phase_q = PH_ABORT;
                                end else begin
                                    exp_r.pwm_command = CMD_START;
                                    phase_q = PH_RAMP;
                                end
                            end
                        end
                        PH_RAMP: begin
                            if (limit_q < cfg_period_final) begin
                                sum = {1'b0, limit_q} + {1'b0, cfg_period_step};
                                limit_q = (sum > {1'b0, cfg_period_final}) ?
                                          cfg_period_final : sum[PERIOD_W-1:0];
                            end
                            if (dt_q > cfg_dt_final) begin
                                if (dt_q >= cfg_dt_step) dt_q = dt_q - cfg_dt_step;
                                else dt_q = cfg_dt_final;
                                if (dt_q < cfg_dt_final) dt_q = cfg_dt_final;
                            end
                            if (limit_q >= cfg_period_final && dt_q <= cfg_dt_final)
                                phase_q = PH_FINAL;
                        end
                        PH_FINAL: begin
                            if (commit_done && running && !fault) begin
                                phase_q = PH_DONE;
                                exp_r.run_request = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end

                req = (req_raw == '0) ? cfg_period_start : req_raw;
                exp_r.applied_period = (req < limit_q) ? req : limit_q;
                if (exp_r.applied_period < PERIOD_FLOOR) exp_r.applied_period = PERIOD_FLOOR;

                if (i_s_user == OP_FAST && ss_on) begin
                    eff = running;
                    if (cfg_burst_en) begin
                        if (req_raw < BURST_THRESHOLD && running) begin
                            if (!burst_on) begin
                                exp_r.pwm_command = CMD_BURST;
                                burst_on = 1'b1;
                                eff = 1'b0;
                            end
                        end else if (burst_on) begin
                            exp_r.pwm_command = CMD_RESTART;
                            burst_on = 1'b0;
                            eff = 1'b1;
                        end
                    end
                    if (eff) begin
                        exp_r.write_valid = 1'b1;
                        if (phase_q == PH_FINAL) begin
                            exp_r.write_period   = cfg_period_final;
                            exp_r.write_deadtime = cfg_dt_final;
                            if (wr_ok) begin
                                if (!commit_first) commit_first = 1'b1;
                                else commit_done = 1'b1;
                            end
                        end else begin
                            exp_r.write_period   = exp_r.applied_period;
                            exp_r.write_deadtime = dt_q;
                        end
                    end
                end

                exp_r.phase      = phase_q;
                exp_r.ramp_limit = limit_q;
                exp_r.deadtime   = dt_q;
                expected_results.push_back(exp_r);
            end
        end
        o_fail_count   <= errors;
        o_outstanding  <= expected_results.size();
        o_result_count <= results;
        o_completed    <= completed;
        o_aborted      <= aborted;
    end

endmodule

### verif/tb_pwm_soft_start_sequencer_core.sv
// Testbench top for pwm_soft_start_sequencer_core: clock, reset, register
// writes and item stimulus with random idling. Checking is done in
// pwmss_seq_checker; depends on pwmss_pkg and the block itself.
module tb_pwm_soft_start_sequencer_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pwmss_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_PCT     = 18;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic [S_USER_W-1:0]   s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    logic steady = 1'b0;
    int   fail_count, outstanding, result_count, completed, aborted;
    int   items_sent   = 0;
    int   random_items = 0;
    int   reg_writes   = 0;
    int   settings_used = 0;
    int   stall_cycles = 0;

    pwm_soft_start_sequencer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    pwmss_seq_checker seq_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_valid      (s_axis_tvalid),
        .i_s_ready      (s_axis_tready),
        .i_s_data       (s_axis_tdata),
        .i_s_user       (s_axis_tuser),
        .i_m_valid      (m_axis_tvalid),
        .i_m_ready      (m_axis_tready),
        .i_m_data       (m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_result_count (result_count),
        .o_completed    (completed),
        .o_aborted      (aborted)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // tdata: [0] in_soft_start, [16:1] req_period, [17] comparator_ok,
    // [18] prepare_ok, [19] pwm_running, [20] fault_present, [21] write_ok
    function automatic logic [S_DATA_W-1:0] pack_item(
        input logic ss, input logic [PERIOD_W-1:0] req, input logic comp,
        input logic prep, input logic run, input logic fault, input logic wr);
        return {2'b00, wr, fault, run, prep, comp, req, ss};
    endfunction

    function automatic logic [PERIOD_W-1:0] pick_request();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return PERIOD_W'($urandom_range(1, 3));
            2: return PERIOD_W'($urandom_range(395, 405));
            3: return '1;
            4: return PERIOD_W'($urandom_range(0, 1100));
            default: return PERIOD_W'($urandom);
        endcase
    endfunction

    task automatic transfer_item(input logic [1:0] op, input logic [S_DATA_W-1:0] data);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // hold off until every issued item has produced its result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic drive_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic set_registers(
        input logic [15:0] p_start, input logic [15:0] p_final, input logic [15:0] p_step,
        input logic [15:0] d_start, input logic [15:0] d_final, input logic [15:0] d_step,
        input logic [15:0] wait_t, input logic [15:0] burst);
        settle();
        drive_reg(REG_PERIOD_START, p_start);
        drive_reg(REG_PERIOD_FINAL, p_final);
        drive_reg(REG_PERIOD_STEP, p_step);
        drive_reg(REG_DEADTIME_START, d_start);
        drive_reg(REG_DEADTIME_FINAL, d_final);
        drive_reg(REG_DEADTIME_STEP, d_step);
        drive_reg(REG_WAIT_TICKS, wait_t);
        drive_reg(REG_BURST_ENABLE, burst);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // begin items clear burst enable, so it is set again after them
    task automatic enable_burst();
        settle();
        drive_reg(REG_BURST_ENABLE, 16'd1);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random_item();
        int         sel;
        logic [1:0] op;
        logic       ss;
        sel = $urandom_range(0, 99);
        if (sel < 4) op = OP_UNUSED;
        else if (sel < 7) op = OP_BEGIN;
        else if (sel < 55) op = OP_SLOW;
        else op = OP_FAST;
        ss = ($urandom_range(0, 99) < 92);
        if (op == OP_BEGIN || (op != OP_UNUSED && ss)) random_items++;
        transfer_item(op, pack_item(ss, pick_request(),
                                    $urandom_range(0, 99) < 90, $urandom_range(0, 99) < 90,
                                    $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 10,
                                    $urandom_range(0, 99) < 80));
    endtask

    initial begin
        int session;
        int seq_len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short ramp: 10 -> 13 -> 14, dead-time 8 -> 3 -> 2
        set_registers(16'd10, 16'd14, 16'd3, 16'd8, 16'd2, 16'd5, 16'd1, 16'd1);
        transfer_item(OP_UNUSED, pack_item(1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        transfer_item(OP_FAST, pack_item(1'b0, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b0, 16'h1234, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_BEGIN, pack_item(1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        enable_burst();
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_BEGIN, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
        transfer_item(OP_BEGIN, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        enable_burst();
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        transfer_item(OP_FAST, pack_item(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_FAST, pack_item(1'b1, 16'd1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_FAST, pack_item(1'b1, 16'd1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_FAST, pack_item(1'b1, 16'd500, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_FAST, pack_item(1'b1, 16'd400, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        transfer_item(OP_FAST, pack_item(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_FAST, pack_item(1'b1, 16'd999, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1));
        transfer_item(OP_SLOW, pack_item(1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
        transfer_item(OP_FAST, pack_item(1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1));

        session = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (session % 7)
                0: set_registers(16'd399, 16'd428, 16'd7, 16'd190, 16'd36, 16'd40,
                                 16'd2, 16'd0);
                1: set_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'd1023, 16'd0, 16'd1023,
                                 16'd0, 16'd1);
                2: set_registers(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd1023, 16'd0,
                                 16'd3, 16'd1);
                3: set_registers(16'd300, 16'd450, 16'd37, 16'd600, 16'd5, 16'd100,
                                 16'd4, 16'd1);
                4: set_registers(16'd100, 16'd200, 16'd0, 16'd50, 16'd10, 16'd0,
                                 16'd1, 16'd0);
                5: set_registers(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                                 16'($urandom_range(1, 100)), 16'($urandom_range(0, 1023)),
                                 16'($urandom_range(0, 1023)), 16'($urandom_range(0, 300)),
                                 16'($urandom_range(0, 5)), 16'($urandom_range(0, 1)));
                default: set_registers(16'd50, 16'd60, 16'd5, 16'd20, 16'd10, 16'd3,
                                       16'hFFFF, 16'd1);
            endcase
            steady <= (session == 3);
            repeat (3) begin
                transfer_item(OP_BEGIN, pack_item(1'($urandom_range(0, 1)), pick_request(),
                                                  1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
                random_items++;
                if ($urandom_range(0, 1)) enable_burst();
                seq_len = $urandom_range(12, 40);
                repeat (seq_len) begin
                    if (items_sent < RANDOM_ITEMS) send_random_item();
                end
            end
            session++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d items (%0d random) under %0d register settings, %0d writes.",
                 items_sent, random_items, settings_used, reg_writes);
        $display("Checked %0d results: %0d soft-starts completed, %0d aborted.",
                 result_count, completed, aborted);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/pwmss_pkg.sv
rtl/core/pwm_soft_start_sequencer_core.sv
rtl/core/pwmss_chk.sv
verif/pwmss_seq_checker.sv
verif/tb_pwm_soft_start_sequencer_core.sv
